@@ rtl/core/uvsg_pkg.sv @@
`timescale 1ns / 1ps

package uvsg_pkg;

  localparam int DIV_STEPS = 16;
  localparam int ATAN_LEN  = 24;

  localparam logic [7:0] RING_COUNT_RST = 8'd16;
  localparam logic [7:0] SEG_COUNT_RST  = 8'd32;
  localparam logic [7:0] RING_COUNT_MIN = 8'd2;
  localparam logic [7:0] SEG_COUNT_MIN  = 8'd3;

  typedef enum logic {
    REG_RING_COUNT    = 1'b0,
    REG_SEGMENT_COUNT = 1'b1
  } reg_idx_t;

  localparam logic signed [33:0] CORDIC_X0 = 34'sh0_26DD_3B6A;
  localparam logic signed [33:0] ONE_Q30   = 34'sh0_4000_0000;
  localparam logic [31:0]        PHI_BASE  = 32'h4000_0000;
  localparam logic signed [63:0] HALF_Y    = 64'sh0000_0000_0000_8000;
  localparam logic signed [63:0] HALF_XZ   = 64'sh0000_2000_0000_0000;

  localparam logic [16:0] TINT_BASE  = 17'd45875;
  localparam logic [14:0] TINT_SCALE = 15'd19661;
  localparam logic [31:0] TINT_HALF  = 32'd32768;

  localparam logic signed [63:0] POS_MAX = 64'sd16384;
  localparam logic signed [63:0] POS_MIN = -64'sd16384;

  localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [31:0] z;
  } rot_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } trig_t;

  typedef struct packed {
    logic [7:0]         ring;
    logic [7:0]         seg;
    logic [7:0]         th_rem;
    logic [7:0]         ph_rem;
    logic [32:0]        th_q;
    logic [32:0]        ph_q;
    logic [1:0]         th_quad;
    logic [1:0]         ph_quad;
    rot_t               th_rot;
    rot_t               ph_rot;
    trig_t              th_trig;
    trig_t              ph_trig;
    logic signed [63:0] prod_x;
    logic signed [63:0] prod_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [16:0]        tint_red;
    logic               quad_valid;
    logic [15:0]        corner_a;
    logic [15:0]        corner_b;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } stage_t;

  // two restoring division steps; returns {remainder, two quotient bits}
  function automatic logic [9:0] div_step2(logic [7:0] r, logic [7:0] d);
    logic [8:0] t;
    logic [7:0] r1;
    logic [7:0] r2;
    logic       b1;
    logic       b2;
    t  = {r, 1'b0};
    b1 = (t >= {1'b0, d});
    r1 = b1 ? 8'(t - {1'b0, d}) : t[7:0];
    t  = {r1, 1'b0};
    b2 = (t >= {1'b0, d});
    r2 = b2 ? 8'(t - {1'b0, d}) : t[7:0];
    return {r2, b1, b2};
  endfunction

  function automatic rot_t cordic_rot(rot_t a, int k);
    rot_t               r;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    dx = a.y >>> k;
    dy = a.x >>> k;
    if (!a.z[31]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - $signed(ATAN_TURNS[k]);
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + $signed(ATAN_TURNS[k]);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_q30(logic signed [33:0] v);
    logic signed [33:0] t;
    t = v;
    if (t > ONE_Q30) t = ONE_Q30;
    if (t < -ONE_Q30) t = -ONE_Q30;
    return t[31:0];
  endfunction

  function automatic trig_t fold(rot_t a, logic [1:0] quad);
    trig_t              r;
    logic signed [33:0] c;
    logic signed [33:0] s;
    case (quad)
      2'd0: begin
        c = a.x;
        s = a.y;
      end
      2'd1: begin
        c = -a.y;
        s = a.x;
      end
      2'd2: begin
        c = -a.x;
        s = -a.y;
      end
      default: begin
        c = a.y;
        s = -a.x;
      end
    endcase
    r.c = clamp_q30(c);
    r.s = clamp_q30(s);
    return r;
  endfunction

  function automatic logic signed [15:0] sat_pos(logic signed [63:0] v);
    logic signed [63:0] t;
    t = v;
    if (t > POS_MAX) t = POS_MAX;
    if (t < POS_MIN) t = POS_MIN;
    return t[15:0];
  endfunction

endpackage

@@ rtl/core/uv_sphere_vertex_generator.sv @@
`timescale 1ns / 1ps
// Throughput: one request per cycle while out_stall is low; the pipeline is set by the divider stages
// (two quotient bits each) and one CORDIC rotation per stage.
// A held result stalls only the stages behind it that are full.
// Reset (synchronous, rst_n low) empties the pipeline and sets 16 rings, 32 segments.

module uv_sphere_vertex_generator
  import uvsg_pkg::*;
#(
  parameter int MAX_RINGS    = 255,
  parameter int MAX_SEGMENTS = 255,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_ring,
  input  logic [7:0]         in_segment,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_pos_z,
  output logic [16:0]        out_tex_u,
  output logic [16:0]        out_tex_v,
  output logic [16:0]        out_tint_red,
  output logic               out_quad_valid,
  output logic [15:0]        out_corner_a,
  output logic [15:0]        out_corner_b
);

  localparam int CI = DIV_STEPS + 1;
  localparam int FS = CI + CORDIC_STEPS + 1;
  localparam int MS = FS + 1;
  localparam int RS = MS + 1;
  localparam int NS = RS + 1;
  localparam int UV = 9;

  localparam logic [9:0] MAX_R = 10'(MAX_RINGS);
  localparam logic [9:0] MAX_S = 10'(MAX_SEGMENTS);

  logic [7:0] ring_count_r;
  logic [7:0] segment_count_r;
  logic [7:0] ring_count_nxt;
  logic [7:0] segment_count_nxt;

  stage_t st_r   [NS];
  stage_t st_nxt [NS];
  logic   valid_r [NS];
  logic   adv [NS+1];

  always_comb begin
    ring_count_nxt = cfg_data;
    if (cfg_data < RING_COUNT_MIN) ring_count_nxt = RING_COUNT_MIN;
    if ({2'b00, cfg_data} > MAX_R) ring_count_nxt = MAX_R[7:0];
    segment_count_nxt = cfg_data;
    if (cfg_data < SEG_COUNT_MIN) segment_count_nxt = SEG_COUNT_MIN;
    if ({2'b00, cfg_data} > MAX_S) segment_count_nxt = MAX_S[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r    <= RING_COUNT_RST;
      segment_count_r <= SEG_COUNT_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_RING_COUNT:    ring_count_r    <= ring_count_nxt;
        REG_SEGMENT_COUNT: segment_count_r <= segment_count_nxt;
        default: ;
      endcase
    end
  end

  assign adv[NS] = !out_stall;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    assign adv[s] = !valid_r[s] || adv[s+1];

    if (s == 0) begin : g_in
      always_comb begin
        logic [7:0] rs;
        logic [7:0] ss;
        logic       th_int;
        logic       ph_int;
        rs     = (in_ring > ring_count_r) ? ring_count_r : in_ring;
        ss     = (in_segment > segment_count_r) ? segment_count_r : in_segment;
        th_int = (ss == segment_count_r);
        ph_int = (rs == ring_count_r);
        st_nxt[s]        = '0;
        st_nxt[s].ring   = rs;
        st_nxt[s].seg    = ss;
        st_nxt[s].th_rem = th_int ? 8'd0 : ss;
        st_nxt[s].ph_rem = ph_int ? 8'd0 : rs;
        st_nxt[s].th_q   = {32'd0, th_int};
        st_nxt[s].ph_q   = {32'd0, ph_int};
      end
    end else if (s <= DIV_STEPS) begin : g_div
      always_comb begin
        logic [9:0]  th_d;
        logic [9:0]  ph_d;
        logic [17:0] a_full;
        logic        qv;
        logic        ru;
        logic        rv;
        th_d = div_step2(st_r[s-1].th_rem, segment_count_r);
        ph_d = div_step2(st_r[s-1].ph_rem, ring_count_r);
        st_nxt[s]        = st_r[s-1];
        st_nxt[s].th_rem = th_d[9:2];
        st_nxt[s].ph_rem = ph_d[9:2];
        st_nxt[s].th_q   = {st_r[s-1].th_q[30:0], th_d[1:0]};
        st_nxt[s].ph_q   = {st_r[s-1].ph_q[30:0], ph_d[1:0]};
        qv = (st_r[s-1].ring < ring_count_r) && (st_r[s-1].seg < segment_count_r);
        a_full = 18'(st_r[s-1].ring) * (18'(segment_count_r) + 18'd1)
               + 18'(st_r[s-1].seg);
        ru = ({1'b0, st_r[s-1].th_rem} + {2'b00, segment_count_r[7:1]})
             >= {1'b0, segment_count_r};
        rv = ({1'b0, st_r[s-1].ph_rem} + {2'b00, ring_count_r[7:1]})
             >= {1'b0, ring_count_r};
        if (s == 1) begin
          st_nxt[s].quad_valid = qv;
          st_nxt[s].corner_a   = qv ? a_full[15:0] : 16'd0;
          st_nxt[s].corner_b   = qv ? 16'(a_full + 18'(segment_count_r) + 18'd1) : 16'd0;
        end
        if (s == UV) begin
          st_nxt[s].tex_u = st_r[s-1].th_q[16:0] + 17'(ru);
          st_nxt[s].tex_v = st_r[s-1].ph_q[16:0] + 17'(rv);
        end
      end
    end else if (s == CI) begin : g_angle
      always_comb begin
        logic [31:0] theta;
        logic [31:0] phi;
        logic [31:0] tv;
        theta = st_r[s-1].th_q[31:0];
        phi   = PHI_BASE - st_r[s-1].ph_q[32:1];
        tv    = 32'(TINT_SCALE) * 32'(st_r[s-1].tex_v) + TINT_HALF;
        st_nxt[s]          = st_r[s-1];
        st_nxt[s].th_quad  = theta[31:30];
        st_nxt[s].ph_quad  = phi[31:30];
        st_nxt[s].th_rot.x = CORDIC_X0;
        st_nxt[s].th_rot.y = '0;
        st_nxt[s].th_rot.z = $signed({2'b00, theta[29:0]});
        st_nxt[s].ph_rot.x = CORDIC_X0;
        st_nxt[s].ph_rot.y = '0;
        st_nxt[s].ph_rot.z = $signed({2'b00, phi[29:0]});
        st_nxt[s].tint_red = TINT_BASE + 17'(tv >> 16);
      end
    end else if (s < FS) begin : g_rot
      always_comb begin
        st_nxt[s]        = st_r[s-1];
        st_nxt[s].th_rot = cordic_rot(st_r[s-1].th_rot, s - CI - 1);
        st_nxt[s].ph_rot = cordic_rot(st_r[s-1].ph_rot, s - CI - 1);
      end
    end else if (s == FS) begin : g_fold
      always_comb begin
        st_nxt[s]         = st_r[s-1];
        st_nxt[s].th_trig = fold(st_r[s-1].th_rot, st_r[s-1].th_quad);
        st_nxt[s].ph_trig = fold(st_r[s-1].ph_rot, st_r[s-1].ph_quad);
      end
    end else if (s == MS) begin : g_mul
      always_comb begin
        st_nxt[s]        = st_r[s-1];
        st_nxt[s].prod_x = st_r[s-1].ph_trig.c * st_r[s-1].th_trig.c;
        st_nxt[s].prod_z = st_r[s-1].ph_trig.c * st_r[s-1].th_trig.s;
        st_nxt[s].pos_y  = sat_pos((64'(st_r[s-1].ph_trig.s) + HALF_Y) >>> 16);
      end
    end else begin : g_round
      always_comb begin
        st_nxt[s]       = st_r[s-1];
        st_nxt[s].pos_x = sat_pos((st_r[s-1].prod_x + HALF_XZ) >>> 46);
        st_nxt[s].pos_z = sat_pos((st_r[s-1].prod_z + HALF_XZ) >>> 46);
      end
    end

    if (s == 0) begin : g_v0
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[s] <= 1'b0;
        end else if (adv[s]) begin
          valid_r[s] <= in_valid;
        end
      end
    end else begin : g_vn
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[s] <= 1'b0;
        end else if (adv[s]) begin
          valid_r[s] <= valid_r[s-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign in_stall       = !adv[0];
  assign out_valid      = valid_r[NS-1];
  assign out_pos_x      = st_r[NS-1].pos_x;
  assign out_pos_y      = st_r[NS-1].pos_y;
  assign out_pos_z      = st_r[NS-1].pos_z;
  assign out_tex_u      = st_r[NS-1].tex_u;
  assign out_tex_v      = st_r[NS-1].tex_v;
  assign out_tint_red   = st_r[NS-1].tint_red;
  assign out_quad_valid = st_r[NS-1].quad_valid;
  assign out_corner_a   = st_r[NS-1].corner_a;
  assign out_corner_b   = st_r[NS-1].corner_b;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input held while output side free");

  a_no_quad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_quad_valid) |-> (out_corner_a == 16'd0 && out_corner_b == 16'd0))
    else $error("corners set on edge point");

  a_tint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tint_red >= TINT_BASE && out_tint_red <= 17'd65536))
    else $error("tint out of range");

  a_pos_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pos_y >= -16'sd16384 && out_pos_y <= 16'sd16384))
    else $error("pos_y out of range");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import uvsg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [7:0] ring;
    logic [7:0] segment;
  } point_t;

  typedef struct {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [16:0]        tint_red;
    logic               quad_valid;
    logic [15:0]        corner_a;
    logic [15:0]        corner_b;
  } vertex_t;

  localparam logic [31:0] ATAN_TAB [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  reg_idx_t           cfg_index;
  logic [7:0]         cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_ring;
  logic [7:0]         in_segment;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_pos_x;
  logic signed [15:0] out_pos_y;
  logic signed [15:0] out_pos_z;
  logic [16:0]        out_tex_u;
  logic [16:0]        out_tex_v;
  logic [16:0]        out_tint_red;
  logic               out_quad_valid;
  logic [15:0]        out_corner_a;
  logic [15:0]        out_corner_b;

  point_t  pending_points[$];
  vertex_t expected_vertices[$];
  int      rings_model;
  int      segments_model;
  int      mismatches;
  int      cycles;
  int      phase;
  int      send_gap;
  int      stall_len;
  int      hold_cnt;
  bit      hold_done;
  bit      idle_on;
  bit      took;

  uv_sphere_vertex_generator u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_ring(in_ring), .in_segment(in_segment),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_tex_u(out_tex_u), .out_tex_v(out_tex_v), .out_tint_red(out_tint_red),
    .out_quad_valid(out_quad_valid), .out_corner_a(out_corner_a),
    .out_corner_b(out_corner_b)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void sin_cos(input logic [31:0] ang, output longint cs, output longint sn);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint c;
    longint s;
    x = 64'h26DD3B6A;
    y = 0;
    z = longint'(ang[29:0]);
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TAB[k]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TAB[k]);
      end
    end
    case (ang[31:30])
      2'd0: begin
        c = x;
        s = y;
      end
      2'd1: begin
        c = -y;
        s = x;
      end
      2'd2: begin
        c = -x;
        s = -y;
      end
      default: begin
        c = y;
        s = -x;
      end
    endcase
    cs = clamp(c, -(64'sd1 <<< 30), 64'sd1 <<< 30);
    sn = clamp(s, -(64'sd1 <<< 30), 64'sd1 <<< 30);
  endfunction

  function automatic vertex_t vertex_of(point_t p);
    vertex_t     r;
    longint      rg;
    longint      sg;
    logic [31:0] theta;
    logic [31:0] phi;
    longint      cphi;
    longint      sphi;
    longint      cth;
    longint      sth;
    longint      v;
    longint      a;
    rg = (p.ring > rings_model) ? rings_model : p.ring;
    sg = (p.segment > segments_model) ? segments_model : p.segment;
    theta = 32'((sg <<< 32) / segments_model);
    phi = 32'h4000_0000 - 32'((rg <<< 31) / rings_model);
    sin_cos(phi, cphi, sphi);
    sin_cos(theta, cth, sth);
    r.pos_y = 16'(clamp((sphi + (64'sd1 <<< 15)) >>> 16, -16384, 16384));
    r.pos_x = 16'(clamp((cphi * cth + (64'sd1 <<< 45)) >>> 46, -16384, 16384));
    r.pos_z = 16'(clamp((cphi * sth + (64'sd1 <<< 45)) >>> 46, -16384, 16384));
    r.tex_u = 17'((sg * 65536 + segments_model / 2) / segments_model);
    v = (rg * 65536 + rings_model / 2) / rings_model;
    r.tex_v = 17'(v);
    r.tint_red = 17'(45875 + ((19661 * v + 32768) >>> 16));
    r.quad_valid = (rg < rings_model) && (sg < segments_model);
    a = r.quad_valid ? rg * (segments_model + 1) + sg : 0;
    r.corner_a = 16'(a);
    r.corner_b = r.quad_valid ? 16'(a + segments_model + 1) : 16'd0;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: hold until accepted, then advance
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || took) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          in_ring <= pending_points[0].ring;
          in_segment <= pending_points[0].segment;
          void'(pending_points.pop_front());
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, including one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (phase == 2 && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= 300;
        out_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else if (stall_len > 0) begin
        stall_len <= stall_len - 1;
        out_stall <= 1'b1;
      end else begin
        stall_len <= pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    point_t  p;
    vertex_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    took <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      p.ring = in_ring;
      p.segment = in_segment;
      expected_vertices = {expected_vertices, vertex_of(p)};
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        e = expected_vertices.pop_front();
        if (out_pos_x !== e.pos_x || out_pos_y !== e.pos_y || out_pos_z !== e.pos_z ||
            out_tex_u !== e.tex_u || out_tex_v !== e.tex_v ||
            out_tint_red !== e.tint_red || out_quad_valid !== e.quad_valid ||
            out_corner_a !== e.corner_a || out_corner_b !== e.corner_b) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch rc=%0d sc=%0d exp %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                   rings_model, segments_model,
                   e.pos_x, e.pos_y, e.pos_z, e.tex_u, e.tex_v, e.tint_red,
                   e.quad_valid, e.corner_a, e.corner_b);
            $display(" got %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                     out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v, out_tint_red,
                     out_quad_valid, out_corner_a, out_corner_b);
          end
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [7:0] value);
    int v;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    v = value;
    if (idx == REG_RING_COUNT) rings_model = (v < 2) ? 2 : v;
    else segments_model = (v < 3) ? 3 : v;
  endtask

  task automatic add_point(int r, int s);
    point_t p;
    p.ring = 8'(r);
    p.segment = 8'(s);
    pending_points = {pending_points, p};
  endtask

  task automatic wait_idle();
    while (pending_points.size() > 0 || in_valid || expected_vertices.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int rset[6];
    int sset[6];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_RING_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    in_ring = '0;
    in_segment = '0;
    out_stall = 1'b0;
    took = 1'b0;
    mismatches = 0;
    cycles = 0;
    phase = 0;
    send_gap = 0;
    stall_len = 0;
    hold_cnt = 0;
    hold_done = 1'b0;
    idle_on = 1'b0;
    rings_model = 16;
    segments_model = 32;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    rset = '{16, 0, 255, 1, 7, 0};
    sset = '{32, 0, 255, 2, 200, 0};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        if (ph == 5) begin
          rset[ph] = $urandom_range(0, 255);
          sset[ph] = $urandom_range(0, 255);
        end
        write_reg(REG_RING_COUNT, 8'(rset[ph]));
        write_reg(REG_SEGMENT_COUNT, 8'(sset[ph]));
      end
      phase = ph;
      idle_on = (ph != 1);
      if (ph == 0) begin
        add_point(0, 0);
        add_point(255, 255);
        add_point(16, 32);
        add_point(15, 31);
        add_point(0, 32);
        add_point(16, 0);
        add_point(8, 8);
        add_point(4, 24);
        add_point(12, 16);
        add_point(8'hAA, 8'h55);
        add_point(8'h55, 8'hAA);
        add_point(17, 33);
      end else begin
        add_point(0, 0);
        add_point(rings_model, segments_model);
        add_point(rings_model - 1, segments_model - 1);
        add_point(255, 0);
      end
      for (int i = 0; i < 140; i++) begin
        if ($urandom_range(0, 9) < 8)
          add_point($urandom_range(0, rings_model), $urandom_range(0, segments_model));
        else
          add_point($urandom_range(0, 255), $urandom_range(0, 255));
      end
      wait_idle();
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ uv_sphere_vertex_generator.f @@
rtl/core/uvsg_pkg.sv
rtl/core/uv_sphere_vertex_generator.sv
dv/testbench.sv
